>>> rtl/qvr_pkg.sv
// Package with the default widths of the rotation block.
package qvr_pkg;

    localparam int DEF_VEC_BITS  = 16;
    localparam int DEF_QUAT_BITS = 16;

endpackage

>>> rtl/qvr_if.sv
// Channel interfaces for the input items and the result items of the rotation block.
interface qvr_in_if
#(
    parameter int VEC_BITS  = 16,
    parameter int QUAT_BITS = 16
);
    logic                        valid;
    logic                        ready;
    logic signed [VEC_BITS-1:0]  vec_x;
    logic signed [VEC_BITS-1:0]  vec_y;
    logic signed [VEC_BITS-1:0]  vec_z;
    logic signed [QUAT_BITS-1:0] quat_i;
    logic signed [QUAT_BITS-1:0] quat_j;
    logic signed [QUAT_BITS-1:0] quat_k;
    logic signed [QUAT_BITS-1:0] quat_w;

    modport source (output valid, vec_x, vec_y, vec_z, quat_i, quat_j, quat_k, quat_w,
                    input ready);
    modport sink   (input valid, vec_x, vec_y, vec_z, quat_i, quat_j, quat_k, quat_w,
                    output ready);
endinterface

interface qvr_out_if
#(
    parameter int VEC_BITS = 16
);
    logic                       valid;
    logic                       ready;
    logic signed [VEC_BITS-1:0] rot_x;
    logic signed [VEC_BITS-1:0] rot_y;
    logic signed [VEC_BITS-1:0] rot_z;
    logic                       clipped;
    logic                       zero_quat;

    modport source (output valid, rot_x, rot_y, rot_z, clipped, zero_quat, input ready);
    modport sink   (input valid, rot_x, rot_y, rot_z, clipped, zero_quat, output ready);
endinterface

>>> rtl/quaternion_vector_rotate.sv
// Pipelined fixed-point rotation of a 3D vector by a quaternion of any length.
//
// The item channel carries a vector (vec_x, vec_y, vec_z) and a quaternion
// (quat_i, quat_j, quat_k, quat_w, signed Q1.14). The result channel carries the
// rotated vector in the scale of the input vector, a clipped flag when any
// component had to be saturated, and a zero_quat flag when the quaternion was
// all zero and the vector was passed through unchanged.
// Each result equals (M*v + 2*w*c + 2*d) / M rounded to nearest (ties away from
// zero), where M is the squared length of the quaternion, c = qv x v and
// d = qv x c. The division by M is exact, so no normalization error builds up.
// The block takes one transaction per cycle while the result channel does not
// stall. It has three multiply and sum stages, one stage that forms the
// dividend, one restoring-division stage per quotient bit (VEC_BITS + 2 of
// them) and the output register.
// Every stage has its own valid bit and moves forward when the stage after it
// is empty or moving, so a stalled receiver only holds the items that are
// queued behind the output register and bubbles are squeezed out.
// Reset clears all valid bits; no result is shown until a new item arrives.
module quaternion_vector_rotate
#(
    parameter int VEC_BITS  = qvr_pkg::DEF_VEC_BITS,
    parameter int QUAT_BITS = qvr_pkg::DEF_QUAT_BITS
)
(
    input  logic      clk,
    input  logic      rst_n,
    qvr_in_if.sink    item,
    qvr_out_if.source result
);
    import qvr_pkg::*;

    // Widths of the intermediate values; all arithmetic is exact.
    localparam int SQW   = 2 * QUAT_BITS;
    localparam int MW    = 2 * QUAT_BITS + 1;
    localparam int PW    = QUAT_BITS + VEC_BITS;
    localparam int CW    = PW + 1;
    localparam int DPW   = QUAT_BITS + CW;
    localparam int DW    = DPW + 1;
    localparam int MVW   = MW + 1 + VEC_BITS;
    localparam int NUMW  = DW + 2;
    localparam int NW    = NUMW + 2;
    localparam int QQ    = VEC_BITS + 2;
    localparam int NS    = QQ + 5;
    localparam int OUTS  = NS - 1;

    // Cross product index pairs: component n is p[A]*r[B] - p[B]*r[A].
    localparam int IA [3] = '{1, 2, 0};
    localparam int IB [3] = '{2, 0, 1};

    logic [NS-1:0] vld_reg;
    logic [NS-1:0] en;

    always_comb
    begin
        en[NS-1] = !vld_reg[NS-1] || result.ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign item.ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= item.valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // Stage 0: squares of the quaternion and products for the first cross product.
    logic signed [VEC_BITS-1:0]  vin [3];
    logic signed [QUAT_BITS-1:0] qin [3];
    logic signed [SQW-1:0]       sq_next [4];
    logic signed [PW-1:0]        pv_next [6];

    logic signed [SQW-1:0]       sq_reg [4];
    logic signed [PW-1:0]        pv_reg [6];
    logic signed [VEC_BITS-1:0]  v0_reg [3];
    logic signed [QUAT_BITS-1:0] q0_reg [3];
    logic signed [QUAT_BITS-1:0] w0_reg;

    assign vin[0] = item.vec_x;
    assign vin[1] = item.vec_y;
    assign vin[2] = item.vec_z;
    assign qin[0] = item.quat_i;
    assign qin[1] = item.quat_j;
    assign qin[2] = item.quat_k;

    always_comb
    begin
        logic signed [SQW-1:0] sa;
        logic signed [PW-1:0]  pa;
        logic signed [PW-1:0]  pb;
        for (int n = 0; n < 3; n++)
        begin
            sa = SQW'(qin[n]);
            sq_next[n] = sa * sa;
            pa = PW'(qin[IA[n]]);
            pb = PW'(vin[IB[n]]);
            pv_next[2*n] = pa * pb;
            pa = PW'(qin[IB[n]]);
            pb = PW'(vin[IA[n]]);
            pv_next[2*n+1] = pa * pb;
        end
        sa = SQW'(item.quat_w);
        sq_next[3] = sa * sa;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            sq_reg <= sq_next;
            pv_reg <= pv_next;
            v0_reg <= vin;
            q0_reg <= qin;
            w0_reg <= item.quat_w;
        end
    end

    // Stage 1: squared length and first cross product c = qv x v.
    logic [MW-1:0]               msq1_reg;
    logic signed [CW-1:0]        c1_reg [3];
    logic signed [VEC_BITS-1:0]  v1_reg [3];
    logic signed [QUAT_BITS-1:0] q1_reg [3];
    logic signed [QUAT_BITS-1:0] w1_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            msq1_reg <= MW'($unsigned(sq_reg[0])) + MW'($unsigned(sq_reg[1]))
                      + MW'($unsigned(sq_reg[2])) + MW'($unsigned(sq_reg[3]));
            for (int n = 0; n < 3; n++)
            begin
                c1_reg[n] <= CW'(pv_reg[2*n]) - CW'(pv_reg[2*n+1]);
            end
            v1_reg <= v0_reg;
            q1_reg <= q0_reg;
            w1_reg <= w0_reg;
        end
    end

    // Stage 2: products for d = qv x c, for M*v and for w*c.
    logic signed [DPW-1:0]       dp_next [6];
    logic signed [MVW-1:0]       mv_next [3];
    logic signed [DPW-1:0]       wc_next [3];

    logic signed [DPW-1:0]       dp_reg [6];
    logic signed [MVW-1:0]       mv_reg [3];
    logic signed [DPW-1:0]       wc_reg [3];
    logic [MW-1:0]               msq2_reg;
    logic signed [VEC_BITS-1:0]  v2_reg [3];

    always_comb
    begin
        logic signed [DPW-1:0] da;
        logic signed [DPW-1:0] db;
        logic signed [MVW-1:0] ma;
        logic signed [MVW-1:0] mb;
        for (int n = 0; n < 3; n++)
        begin
            da = DPW'(q1_reg[IA[n]]);
            db = DPW'(c1_reg[IB[n]]);
            dp_next[2*n] = da * db;
            da = DPW'(q1_reg[IB[n]]);
            db = DPW'(c1_reg[IA[n]]);
            dp_next[2*n+1] = da * db;
            da = DPW'(w1_reg);
            db = DPW'(c1_reg[n]);
            wc_next[n] = da * db;
            ma = MVW'(msq1_reg);
            mb = MVW'(v1_reg[n]);
            mv_next[n] = ma * mb;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            dp_reg   <= dp_next;
            mv_reg   <= mv_next;
            wc_reg   <= wc_next;
            msq2_reg <= msq1_reg;
            v2_reg   <= v1_reg;
        end
    end

    // Division pipeline: entry 0 holds the dividend 2|num| + M and divisor 2M,
    // entry k+1 has quotient bit QQ-1-k resolved.
    logic [NW-1:0]              rem_reg  [QQ+1][3];
    logic [QQ-1:0]              quo_reg  [QQ+1][3];
    logic                       neg_reg  [QQ+1][3];
    logic [NW-1:0]              den_reg  [QQ+1];
    logic                       zero_reg [QQ+1];
    logic signed [VEC_BITS-1:0] vd_reg   [QQ+1][3];

    // Stage 3: numerator, its sign and magnitude.
    always_ff @(posedge clk)
    begin
        logic signed [DW-1:0]   d;
        logic signed [NUMW-1:0] num;
        logic [NUMW-1:0]        mag;
        if (en[3])
        begin
            for (int n = 0; n < 3; n++)
            begin
                d   = DW'(dp_reg[2*n]) - DW'(dp_reg[2*n+1]);
                num = NUMW'(mv_reg[n]) + (NUMW'(wc_reg[n]) <<< 1) + (NUMW'(d) <<< 1);
                mag = num[NUMW-1] ? NUMW'(-num) : NUMW'(num);
                rem_reg[0][n] <= (NW'(mag) << 1) + NW'(msq2_reg);
                quo_reg[0][n] <= '0;
                neg_reg[0][n] <= num[NUMW-1];
                vd_reg[0][n]  <= v2_reg[n];
            end
            den_reg[0]  <= NW'(msq2_reg) << 1;
            zero_reg[0] <= (msq2_reg == '0);
        end
    end

    // One restoring-division step per stage; the rotated vector is bounded by
    // the vector length, so QQ quotient bits always suffice.
    for (genvar g = 0; g < QQ; g++)
    begin : g_div
        localparam int BIT = QQ - 1 - g;

        always_ff @(posedge clk)
        begin
            logic [NW-1:0] sub;
            if (en[4+g])
            begin
                sub = den_reg[g] << BIT;
                for (int n = 0; n < 3; n++)
                begin
                    if (rem_reg[g][n] >= sub)
                    begin
                        rem_reg[g+1][n] <= rem_reg[g][n] - sub;
                        quo_reg[g+1][n] <= quo_reg[g][n] | (QQ'(1) << BIT);
                    end
                    else
                    begin
                        rem_reg[g+1][n] <= rem_reg[g][n];
                        quo_reg[g+1][n] <= quo_reg[g][n];
                    end
                    neg_reg[g+1][n] <= neg_reg[g][n];
                    vd_reg[g+1][n]  <= vd_reg[g][n];
                end
                den_reg[g+1]  <= den_reg[g];
                zero_reg[g+1] <= zero_reg[g];
            end
        end
    end

    // Output stage: sign, saturation and the zero quaternion bypass.
    localparam logic [QQ-1:0] LIM = QQ'(1) << (VEC_BITS - 1);

    logic signed [VEC_BITS-1:0] rot_reg [3];
    logic                       clip_reg;
    logic                       zq_reg;

    always_ff @(posedge clk)
    begin
        logic [QQ-1:0] r;
        logic          clip;
        if (en[OUTS])
        begin
            clip = 1'b0;
            for (int n = 0; n < 3; n++)
            begin
                r = quo_reg[QQ][n];
                if (neg_reg[QQ][n])
                begin
                    if (r > LIM)
                    begin
                        r    = LIM;
                        clip = 1'b1;
                    end
                    r = -r;
                end
                else if (r > LIM - QQ'(1))
                begin
                    r    = LIM - QQ'(1);
                    clip = 1'b1;
                end
                rot_reg[n] <= zero_reg[QQ] ? vd_reg[QQ][n] : $signed(r[VEC_BITS-1:0]);
            end
            clip_reg <= clip && !zero_reg[QQ];
            zq_reg   <= zero_reg[QQ];
        end
    end

    assign result.valid     = vld_reg[OUTS];
    assign result.rot_x     = rot_reg[0];
    assign result.rot_y     = rot_reg[1];
    assign result.rot_z     = rot_reg[2];
    assign result.clipped   = clip_reg;
    assign result.zero_quat = zq_reg;

endmodule
